>>> hw/rtl/cascaded_biquad_iir_filter_unit_assert.svh
// Assertion macros for the biquad cascade checker.
`ifndef CASCADED_BIQUAD_IIR_FILTER_UNIT_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CBQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CBQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hw/rtl/cbq_pkg.sv
// Types, constants and rounding functions of the biquad cascade.
package cbq_pkg;

  localparam int unsigned CBQ_NUM_STAGES = 8;
  localparam int unsigned CBQ_COEFS      = 5;
  localparam int unsigned CBQ_ACC_W      = 42;
  localparam int unsigned CBQ_COEF_W     = 16;
  localparam int unsigned CBQ_DLY_W      = 24;
  localparam int unsigned CBQ_SMP_W      = 16;

  localparam logic CBQ_ACT_SAMPLE = 1'b0;
  localparam logic CBQ_ACT_COEF   = 1'b1;

  localparam logic [2:0] CBQ_SLOT_B0 = 3'd0;
  localparam logic [2:0] CBQ_SLOT_B1 = 3'd1;
  localparam logic [2:0] CBQ_SLOT_B2 = 3'd2;
  localparam logic [2:0] CBQ_SLOT_A1 = 3'd3;
  localparam logic [2:0] CBQ_SLOT_A2 = 3'd4;

  localparam logic [2:0] CBQ_OP_A1 = 3'd0;
  localparam logic [2:0] CBQ_OP_A2 = 3'd1;
  localparam logic [2:0] CBQ_OP_B0 = 3'd2;
  localparam logic [2:0] CBQ_OP_B1 = 3'd3;
  localparam logic [2:0] CBQ_OP_B2 = 3'd4;

  localparam logic [2:0] CBQ_FETCH_LAST = 3'd5;

  localparam logic signed [CBQ_ACC_W-1:0] CBQ_HALF_W = CBQ_ACC_W'(8192);
  localparam logic signed [CBQ_ACC_W-1:0] CBQ_HALF_Y = CBQ_ACC_W'(524288);
  localparam logic signed [CBQ_ACC_W-1:0] CBQ_W_MAX  = CBQ_ACC_W'(8388607);
  localparam logic signed [CBQ_ACC_W-1:0] CBQ_W_MIN  = CBQ_ACC_W'(-8388608);
  localparam logic signed [CBQ_ACC_W-1:0] CBQ_Y_MAX  = CBQ_ACC_W'(32767);
  localparam logic signed [CBQ_ACC_W-1:0] CBQ_Y_MIN  = CBQ_ACC_W'(-32768);

  typedef struct packed {
    logic                        action;
    logic signed [CBQ_SMP_W-1:0] sample_in;
    logic                        block_end;
    logic [2:0]                  stage_select;
    logic [2:0]                  coef_slot;
    logic signed [CBQ_COEF_W-1:0] coef_value;
  } cbq_in_t;

  typedef struct packed {
    logic signed [CBQ_SMP_W-1:0] sample_out;
    logic                        clipped;
    logic                        block_end_out;
  } cbq_out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic sub;
  } cbq_mac_cmd_t;

  typedef struct packed {
    logic                        clip;
    logic signed [CBQ_DLY_W-1:0] val;
  } cbq_w_t;

  typedef struct packed {
    logic                        clip;
    logic signed [CBQ_SMP_W-1:0] val;
  } cbq_y_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC_GO,
    ST_MAC_RUN,
    ST_RND_W,
    ST_RND_Y,
    ST_WB_W1,
    ST_WB_W2,
    ST_OUT
  } cbq_state_e;

  // Round the w sum to Q3.21 and saturate.
  function automatic cbq_w_t cbq_round_w(input logic signed [CBQ_ACC_W-1:0] acc);
    logic signed [CBQ_ACC_W-1:0] t;
    cbq_w_t r;
    t = (acc + CBQ_HALF_W) >>> 14;
    if (t > CBQ_W_MAX) begin
      r.clip = 1'b1;
      r.val  = CBQ_W_MAX[CBQ_DLY_W-1:0];
    end else if (t < CBQ_W_MIN) begin
      r.clip = 1'b1;
      r.val  = CBQ_W_MIN[CBQ_DLY_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = t[CBQ_DLY_W-1:0];
    end
    return r;
  endfunction

  // Round the y sum to Q1.15 and saturate.
  function automatic cbq_y_t cbq_round_y(input logic signed [CBQ_ACC_W-1:0] acc);
    logic signed [CBQ_ACC_W-1:0] t;
    cbq_y_t r;
    t = (acc + CBQ_HALF_Y) >>> 20;
    if (t > CBQ_Y_MAX) begin
      r.clip = 1'b1;
      r.val  = CBQ_Y_MAX[CBQ_SMP_W-1:0];
    end else if (t < CBQ_Y_MIN) begin
      r.clip = 1'b1;
      r.val  = CBQ_Y_MIN[CBQ_SMP_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = t[CBQ_SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/cascaded_biquad_iir_filter_unit.sv
// Cascade of direct-form-II biquad sections sharing one bit-serial MAC.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): a word with action
// coefficient writes one of b0, b1, b2, a1, a2 of one stage and does not
// stall; writes to a stage at or past NUM_STAGES or a slot above a2 drop.
// A sample word runs through every stage in turn and yields one output word.
// Output channel (out_valid_o / out_stall_i / out_word_o): the filtered
// sample, a clip flag (any delay or stage output saturated) and the copy of
// block_end. The output sits in a register, so a new word is taken while a
// finished result still waits on a stalled receiver.
// Sequence: each stage fetches its five coefficients and two delays, then
// runs five bit-serial multiplies, rounds twice and writes back two
// delays; the pace is set by the one-bit-per-cycle MAC. The input stalls
// from the moment a sample is taken until its result is loaded into the
// output register, so a new sample or coefficient write waits until then.
// Reset clears all coefficients and delays to zero through per-entry valid
// bits; the block takes words right after reset. A stalled receiver holds
// the last result and keeps the next sample waiting in its final state.
module cascaded_biquad_iir_filter_unit #(
  parameter int unsigned NUM_STAGES = cbq_pkg::CBQ_NUM_STAGES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cbq_pkg::cbq_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cbq_pkg::cbq_out_t out_word_o
);

  localparam int unsigned SW     = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int unsigned CDEPTH = NUM_STAGES * cbq_pkg::CBQ_COEFS;
  localparam int unsigned CAW    = $clog2(CDEPTH);
  localparam int unsigned DDEPTH = 2 * NUM_STAGES;
  localparam int unsigned DAW    = $clog2(DDEPTH);

  cbq_pkg::cbq_state_e state_q, state_d;

  logic [SW-1:0] stage_q;
  logic [2:0]    fcnt_q;
  logic [2:0]    op_q;
  logic          in_acc;
  logic          smp_acc;

  // coefficient memory
  logic signed [cbq_pkg::CBQ_COEF_W-1:0] coef_mem [CDEPTH];
  logic [CDEPTH-1:0]                     coef_vld_q;
  logic signed [cbq_pkg::CBQ_COEF_W-1:0] coef_rd_q;
  logic                                  coef_rdv_q;
  logic                                  coef_we;
  logic                                  coef_re;
  logic [CAW-1:0]                        coef_waddr;
  logic [CAW-1:0]                        coef_raddr;

  // delay memory
  logic signed [cbq_pkg::CBQ_DLY_W-1:0] dly_mem [DDEPTH];
  logic [DDEPTH-1:0]                    dly_vld_q;
  logic signed [cbq_pkg::CBQ_DLY_W-1:0] dly_rd_q;
  logic                                 dly_rdv_q;
  logic                                 dly_re;
  logic                                 dly_we;
  logic                                 dly_wsel;
  logic [DAW-1:0]                       dly_raddr;
  logic [DAW-1:0]                       dly_waddr;
  logic signed [cbq_pkg::CBQ_DLY_W-1:0] dly_wdata;

  // per-stage working registers
  logic signed [cbq_pkg::CBQ_COEF_W-1:0] coef_q [cbq_pkg::CBQ_COEFS];
  logic signed [cbq_pkg::CBQ_DLY_W-1:0]  w_q, w1_q, w2_q;
  logic signed [cbq_pkg::CBQ_SMP_W-1:0]  x_q;
  logic                                  clip_q;
  logic                                  bend_q;
  logic signed [cbq_pkg::CBQ_COEF_W-1:0] coef_val;
  logic signed [cbq_pkg::CBQ_DLY_W-1:0]  dly_val;

  // MAC interface
  cbq_pkg::cbq_mac_cmd_t                 mac_cmd;
  logic signed [cbq_pkg::CBQ_ACC_W-1:0]  mac_load;
  logic signed [cbq_pkg::CBQ_COEF_W-1:0] mac_coef;
  logic signed [cbq_pkg::CBQ_DLY_W-1:0]  mac_mcand;
  logic                                  mac_sub;
  logic                                  mac_busy;
  logic signed [cbq_pkg::CBQ_ACC_W-1:0]  mac_acc;
  logic signed [cbq_pkg::CBQ_ACC_W-1:0]  x_ext;

  cbq_pkg::cbq_w_t rnd_w;
  cbq_pkg::cbq_y_t rnd_y;

  logic              out_valid_q;
  logic              out_load;
  cbq_pkg::cbq_out_t out_q;

  assign in_stall_o = (state_q != cbq_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign smp_acc    = in_acc && (in_word_i.action == cbq_pkg::CBQ_ACT_SAMPLE);

  // Drop writes that point past the last stage or the last slot.
  assign coef_we = in_acc && (in_word_i.action == cbq_pkg::CBQ_ACT_COEF) &&
                   (int'(in_word_i.stage_select) < int'(NUM_STAGES)) &&
                   (in_word_i.coef_slot <= cbq_pkg::CBQ_SLOT_A2);
  assign coef_waddr = CAW'(6'({in_word_i.stage_select, 2'b00}) +
                           6'(in_word_i.stage_select) + 6'(in_word_i.coef_slot));
  assign coef_raddr = CAW'((SW+3)'({stage_q, 2'b00}) + (SW+3)'(stage_q) +
                           (SW+3)'(fcnt_q));
  assign dly_raddr  = DAW'({stage_q, fcnt_q[0]});
  assign dly_waddr  = DAW'({stage_q, dly_wsel});
  assign dly_wdata  = dly_wsel ? w1_q : w_q;

  // Entries never written read as zero.
  assign coef_val = coef_rdv_q ? coef_rd_q : '0;
  assign dly_val  = dly_rdv_q ? dly_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_word_i.coef_value;
    end
    if (coef_re) begin
      coef_rd_q <= coef_mem[coef_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[dly_waddr] <= dly_wdata;
    end
    if (dly_re) begin
      dly_rd_q <= dly_mem[dly_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      dly_vld_q  <= '0;
      coef_rdv_q <= 1'b0;
      dly_rdv_q  <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
      if (dly_we) begin
        dly_vld_q[dly_waddr] <= 1'b1;
      end
      if (coef_re) begin
        coef_rdv_q <= coef_vld_q[coef_raddr];
      end
      if (dly_re) begin
        dly_rdv_q <= dly_vld_q[dly_raddr];
      end
    end
  end

  // Pick MAC operands for the current product.
  always_comb begin
    mac_coef  = coef_q[cbq_pkg::CBQ_SLOT_A1];
    mac_mcand = w1_q;
    mac_sub   = 1'b1;
    unique case (op_q)
      cbq_pkg::CBQ_OP_A1: begin
        mac_coef  = coef_q[cbq_pkg::CBQ_SLOT_A1];
        mac_mcand = w1_q;
        mac_sub   = 1'b1;
      end
      cbq_pkg::CBQ_OP_A2: begin
        mac_coef  = coef_q[cbq_pkg::CBQ_SLOT_A2];
        mac_mcand = w2_q;
        mac_sub   = 1'b1;
      end
      cbq_pkg::CBQ_OP_B0: begin
        mac_coef  = coef_q[cbq_pkg::CBQ_SLOT_B0];
        mac_mcand = w_q;
        mac_sub   = 1'b0;
      end
      cbq_pkg::CBQ_OP_B1: begin
        mac_coef  = coef_q[cbq_pkg::CBQ_SLOT_B1];
        mac_mcand = w1_q;
        mac_sub   = 1'b0;
      end
      cbq_pkg::CBQ_OP_B2: begin
        mac_coef  = coef_q[cbq_pkg::CBQ_SLOT_B2];
        mac_mcand = w2_q;
        mac_sub   = 1'b0;
      end
      default: begin
        mac_coef  = '0;
        mac_mcand = '0;
        mac_sub   = 1'b0;
      end
    endcase
  end

  // The stage input enters the w sum at scale 2^20.
  assign x_ext = cbq_pkg::CBQ_ACC_W'(x_q);
  assign rnd_w = cbq_pkg::cbq_round_w(mac_acc);
  assign rnd_y = cbq_pkg::cbq_round_y(mac_acc);

  always_comb begin
    state_d  = state_q;
    mac_cmd  = '0;
    mac_load = '0;
    coef_re  = 1'b0;
    dly_re   = 1'b0;
    dly_we   = 1'b0;
    dly_wsel = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      cbq_pkg::ST_IDLE: begin
        if (smp_acc) begin
          state_d = cbq_pkg::ST_FETCH;
        end
      end
      cbq_pkg::ST_FETCH: begin
        coef_re = (fcnt_q < cbq_pkg::CBQ_SLOT_A2 + 3'd1);
        dly_re  = (fcnt_q < 3'd2);
        if (fcnt_q == cbq_pkg::CBQ_FETCH_LAST) begin
          mac_cmd.load = 1'b1;
          mac_load     = x_ext <<< 20;
          state_d      = cbq_pkg::ST_MAC_GO;
        end
      end
      cbq_pkg::ST_MAC_GO: begin
        mac_cmd.start = 1'b1;
        mac_cmd.sub   = mac_sub;
        state_d       = cbq_pkg::ST_MAC_RUN;
      end
      cbq_pkg::ST_MAC_RUN: begin
        if (!mac_busy) begin
          priority if (op_q == cbq_pkg::CBQ_OP_A2) begin
            state_d = cbq_pkg::ST_RND_W;
          end else if (op_q == cbq_pkg::CBQ_OP_B2) begin
            state_d = cbq_pkg::ST_RND_Y;
          end else begin
            state_d = cbq_pkg::ST_MAC_GO;
          end
        end
      end
      cbq_pkg::ST_RND_W: begin
        // Clear the accumulator for the y sum.
        mac_cmd.load = 1'b1;
        mac_load     = '0;
        state_d      = cbq_pkg::ST_MAC_GO;
      end
      cbq_pkg::ST_RND_Y: begin
        state_d = cbq_pkg::ST_WB_W1;
      end
      cbq_pkg::ST_WB_W1: begin
        dly_we   = 1'b1;
        dly_wsel = 1'b0;
        state_d  = cbq_pkg::ST_WB_W2;
      end
      cbq_pkg::ST_WB_W2: begin
        dly_we   = 1'b1;
        dly_wsel = 1'b1;
        if (stage_q == SW'(NUM_STAGES - 1)) begin
          state_d = cbq_pkg::ST_OUT;
        end else begin
          state_d = cbq_pkg::ST_FETCH;
        end
      end
      cbq_pkg::ST_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = cbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbq_pkg::ST_IDLE;
      stage_q     <= '0;
      fcnt_q      <= '0;
      op_q        <= cbq_pkg::CBQ_OP_A1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (smp_acc) begin
        stage_q <= '0;
        fcnt_q  <= '0;
      end else if (state_q == cbq_pkg::ST_FETCH) begin
        fcnt_q <= fcnt_q + 3'd1;
        if (fcnt_q == cbq_pkg::CBQ_FETCH_LAST) begin
          op_q <= cbq_pkg::CBQ_OP_A1;
        end
      end else if (state_q == cbq_pkg::ST_MAC_RUN && !mac_busy &&
                   op_q != cbq_pkg::CBQ_OP_A2 && op_q != cbq_pkg::CBQ_OP_B2) begin
        op_q <= op_q + 3'd1;
      end else if (state_q == cbq_pkg::ST_RND_W) begin
        op_q <= cbq_pkg::CBQ_OP_B0;
      end else if (state_q == cbq_pkg::ST_WB_W2) begin
        // Advance to the next stage.
        fcnt_q <= '0;
        if (stage_q != SW'(NUM_STAGES - 1)) begin
          stage_q <= stage_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      x_q    <= in_word_i.sample_in;
      bend_q <= in_word_i.block_end;
      clip_q <= 1'b0;
    end
    if (state_q == cbq_pkg::ST_FETCH && fcnt_q != 3'd0) begin
      coef_q[fcnt_q - 3'd1] <= coef_val;
      if (fcnt_q == 3'd1) begin
        w1_q <= dly_val;
      end
      if (fcnt_q == 3'd2) begin
        w2_q <= dly_val;
      end
    end
    if (state_q == cbq_pkg::ST_RND_W) begin
      w_q <= rnd_w.val;
      if (rnd_w.clip) begin
        clip_q <= 1'b1;
      end
    end
    if (state_q == cbq_pkg::ST_RND_Y) begin
      x_q <= rnd_y.val;
      if (rnd_y.clip) begin
        clip_q <= 1'b1;
      end
    end
    if (out_load) begin
      out_q.sample_out    <= x_q;
      out_q.clipped       <= clip_q;
      out_q.block_end_out <= bend_q;
    end
  end

  cbq_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (mac_cmd),
    .load_val_i (mac_load),
    .coef_i     (mac_coef),
    .mcand_i    (mac_mcand),
    .busy_o     (mac_busy),
    .acc_o      (mac_acc)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> hw/rtl/cbq_mac.sv
// Bit-serial multiply-accumulate unit, one coefficient bit per cycle.
module cbq_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cbq_pkg::cbq_mac_cmd_t                  cmd_i,
  input  logic signed [cbq_pkg::CBQ_ACC_W-1:0]   load_val_i,
  input  logic signed [cbq_pkg::CBQ_COEF_W-1:0]  coef_i,
  input  logic signed [cbq_pkg::CBQ_DLY_W-1:0]   mcand_i,
  output logic                                   busy_o,
  output logic signed [cbq_pkg::CBQ_ACC_W-1:0]   acc_o
);

  localparam int unsigned CW = $clog2(cbq_pkg::CBQ_COEF_W);

  logic signed [cbq_pkg::CBQ_ACC_W-1:0] acc_q, acc_d;
  logic signed [cbq_pkg::CBQ_ACC_W-1:0] mc_q, mc_d;
  logic [cbq_pkg::CBQ_COEF_W-1:0]       bits_q, bits_d;
  logic [CW-1:0]                        cnt_q, cnt_d;
  logic                                 busy_q, busy_d;
  logic                                 sub_q, sub_d;
  logic                                 last;
  logic                                 neg;

  assign last = (cnt_q == CW'(cbq_pkg::CBQ_COEF_W - 1));
  // The top coefficient bit carries negative weight.
  assign neg  = sub_q ^ last;

  always_comb begin
    acc_d  = acc_q;
    mc_d   = mc_q;
    bits_d = bits_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sub_d  = sub_q;
    if (cmd_i.load) begin
      acc_d = load_val_i;
    end
    if (cmd_i.start) begin
      mc_d   = cbq_pkg::CBQ_ACC_W'(mcand_i);
      bits_d = coef_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      sub_d  = cmd_i.sub;
    end else if (busy_q) begin
      if (bits_q[0]) begin
        acc_d = neg ? (acc_q - mc_q) : (acc_q + mc_q);
      end
      mc_d   = mc_q <<< 1;
      bits_d = bits_q >> 1;
      cnt_d  = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      sub_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      sub_q  <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    mc_q   <= mc_d;
    bits_q <= bits_d;
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

>>> hw/rtl/cbq_checker.sv
// Port-level checker for the biquad cascade, bound to the top level.
`include "cascaded_biquad_iir_filter_unit_assert.svh"

module cbq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input cbq_pkg::cbq_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cbq_pkg::cbq_out_t out_word_o
);

  `CBQ_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)
  `CBQ_ASSERT_NEXT(a_out_word_holds, out_valid_o && out_stall_i, $stable(out_word_o))
  `CBQ_ASSERT_NEXT(a_sample_busy,
    in_valid_i && !in_stall_o && in_word_i.action == cbq_pkg::CBQ_ACT_SAMPLE, in_stall_o)
  `CBQ_ASSERT_NEXT(a_write_one_cycle,
    in_valid_i && !in_stall_o && in_word_i.action == cbq_pkg::CBQ_ACT_COEF, !in_stall_o)
  `CBQ_ASSERT_NOW(a_result_ends_work, $rose(out_valid_o), $fell(in_stall_o))

endmodule

bind cascaded_biquad_iir_filter_unit cbq_checker u_cbq_checker (.*);
